// File: rtl/core/srv_pkg.sv
// Shared types and fixed constants of the Schroeder reverb core.
package srv_pkg;

  localparam int CDLY_W    = 11;
  localparam int ADLY_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COMB1_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMB2_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB3_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMB4_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS1_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS2_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIX            = 3'd7;

  localparam logic [CDLY_W-1:0] COMB1_DELAY_RST    = 11'd661;
  localparam logic [CDLY_W-1:0] COMB2_DELAY_RST    = 11'd749;
  localparam logic [CDLY_W-1:0] COMB3_DELAY_RST    = 11'd859;
  localparam logic [CDLY_W-1:0] COMB4_DELAY_RST    = 11'd970;
  localparam logic [ADLY_W-1:0] ALLPASS1_DELAY_RST = 8'd220;
  localparam logic [ADLY_W-1:0] ALLPASS2_DELAY_RST = 8'd74;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic load;
  } mac_ctl_t;

endpackage

// File: rtl/core/schroeder_reverb_core.sv
// Schroeder reverb core: four damped combs, two allpasses and a dry/wet mix.
//
// Input samples arrive on the in_ stream, one signed sample per transfer, and
// each produces exactly one mixed sample on the out_ stream. Registers are
// written through the cfg_ channel (index, data); cfg_ready is always high and
// writes are meant to happen while no sample is in flight.
// One multiply-accumulate unit is shared by every product, so a sample walks
// through a small sequencer: five steps per comb, two per allpass and three
// for the mix. A new input is taken only once the previous sample has been
// handed to the output register and the sequencer is idle again.
// The finished result sits in an output register; if the receiver stalls, the
// next sample is still taken and processed, and waits in its last step until
// the output register is free.
// After reset the ring memories are swept to zero, one word of each memory per
// cycle, across 8192 addresses at the default depths (the larger of four comb
// rings or two allpass rings, rounded up to a power of two). in_tready stays
// low until the sweep is done; the registers take their reset values.
module schroeder_reverb_core
  import srv_pkg::*;
#(
  parameter int COMB_DEPTH     = 2048,
  parameter int ALLPASS_DEPTH  = 256,
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // sample_in, then zero pad
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,  // sample_out, then zero pad
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [COEF_FRAC_BITS:0]               cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CF   = COEF_FRAC_BITS;
  localparam int CW   = CF + 1;
  localparam int AW   = SW + CF + 3;
  localparam int SATW = AW + 1;
  localparam int CIW  = $clog2(COMB_DEPTH);
  localparam int AIW  = $clog2(ALLPASS_DEPTH);
  localparam int PW   = (CIW > AIW) ? CIW : AIW;
  localparam int LENW = (PW + 1 > CDLY_W + 1) ? PW + 1 : CDLY_W + 1;
  localparam int CMW  = CIW + 2;
  localparam int AMW  = AIW + 1;
  localparam int CLRW = (CMW > AMW) ? CMW : AMW;

  localparam logic [CW-1:0] COEF_ONE  = CW'(64'd1 << CF);
  localparam logic [CW-1:0] FEEDBACK  = CW'((8 * (64'd1 << CF) + 5) / 10);
  localparam logic [CW-1:0] DAMP_RST  = CW'(64'd1 << (CF - 1));
  localparam logic [CW-1:0] MIX_RST   = CW'((3 * (64'd1 << CF) + 5) / 10);
  localparam logic signed [SATW-1:0] S_MAX = SATW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SATW-1:0] S_MIN = -S_MAX - SATW'(1);
  localparam logic signed [SATW-1:0] ONE_S = SATW'(1);
  localparam logic signed [SW+1:0]   SUM_TWO = (SW+2)'(2);
  localparam logic [CLRW-1:0]        CLR_LAST = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CRD, S_CMAC, S_CLP, S_CFB, S_CWR,
    S_ARD, S_AWR, S_M1, S_M2, S_OUT
  } state_t;

  function automatic logic signed [SW-1:0] sat(input logic signed [SATW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > S_MAX) begin
      r = S_MAX[SW-1:0];
    end else if (v < S_MIN) begin
      r = S_MIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CDLY_W-1:0] comb_dly_r [4];
  logic [ADLY_W-1:0] ap_dly_r [2];
  logic [CW-1:0]     damp_r;
  logic [CW-1:0]     mix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comb_dly_r[0] <= COMB1_DELAY_RST;
      comb_dly_r[1] <= COMB2_DELAY_RST;
      comb_dly_r[2] <= COMB3_DELAY_RST;
      comb_dly_r[3] <= COMB4_DELAY_RST;
      ap_dly_r[0]   <= ALLPASS1_DELAY_RST;
      ap_dly_r[1]   <= ALLPASS2_DELAY_RST;
      damp_r        <= DAMP_RST;
      mix_r         <= MIX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COMB1_DELAY:    comb_dly_r[0] <= cfg_data[CDLY_W-1:0];
        REG_COMB2_DELAY:    comb_dly_r[1] <= cfg_data[CDLY_W-1:0];
        REG_COMB3_DELAY:    comb_dly_r[2] <= cfg_data[CDLY_W-1:0];
        REG_COMB4_DELAY:    comb_dly_r[3] <= cfg_data[CDLY_W-1:0];
        REG_ALLPASS1_DELAY: ap_dly_r[0]   <= cfg_data[ADLY_W-1:0];
        REG_ALLPASS2_DELAY: ap_dly_r[1]   <= cfg_data[ADLY_W-1:0];
        REG_DAMPING:        damp_r        <= cfg_data;
        REG_MIX:            mix_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficients above one act as exactly one.
  logic [CW-1:0] d_eff, one_m_d, m_eff, one_m_m;
  assign d_eff   = (damp_r > COEF_ONE) ? COEF_ONE : damp_r;
  assign one_m_d = COEF_ONE - d_eff;
  assign m_eff   = (mix_r > COEF_ONE) ? COEF_ONE : mix_r;
  assign one_m_m = COEF_ONE - m_eff;

  // Sequencer state.
  state_t                state_r, state_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [CLRW-1:0]       clr_r, clr_nxt;
  logic signed [SW-1:0]  x_r, x_nxt;
  logic signed [SW+1:0]  sum_r, sum_nxt;
  logic signed [SW-1:0]  v_r, v_nxt;
  logic signed [SW-1:0]  lpv_r, lpv_nxt;
  logic [PW-1:0]         peff_r, peff_nxt;
  logic [PW-1:0]         nidx_r, nidx_nxt;
  logic [PW-1:0]         pos_r [6];
  logic [PW-1:0]         pos_nxt [6];
  logic signed [SW-1:0]  lp_r [4];
  logic signed [SW-1:0]  lp_nxt [4];
  logic signed [SW-1:0]  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Ring memories.
  logic signed [SW-1:0] cm_mem [0:(1<<CMW)-1];
  logic signed [SW-1:0] am_mem [0:(1<<AMW)-1];
  logic signed [SW-1:0] cm_rdata_r, am_rdata_r;
  logic [CMW-1:0]       cm_raddr, cm_waddr;
  logic [AMW-1:0]       am_raddr, am_waddr;
  logic                 cm_we, am_we;
  logic signed [SW-1:0] cm_wdata, am_wdata;

  // Shared multiply-accumulate unit.
  mac_ctl_t             mac_ctl;
  logic signed [SW-1:0] mac_a;
  logic [CW-1:0]        mac_b;
  logic signed [AW-1:0] mac_acc;
  logic signed [AW-1:0] acc_sh;

  srv_mac #(
    .SAMPLE_WIDTH   (SW),
    .COEF_FRAC_BITS (CF)
  ) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  assign acc_sh = mac_acc >>> CF;

  // Ring position arithmetic for the filter selected by k_r.
  logic [CDLY_W-1:0] dly_sel;
  logic [LENW-1:0]   depth_sel, dly_p1, ring_len, pos_ext, peff, peff_p1, rd_idx;

  always_comb begin
    case (k_r)
      3'd0:    dly_sel = comb_dly_r[0];
      3'd1:    dly_sel = comb_dly_r[1];
      3'd2:    dly_sel = comb_dly_r[2];
      3'd3:    dly_sel = comb_dly_r[3];
      3'd4:    dly_sel = CDLY_W'(ap_dly_r[0]);
      3'd5:    dly_sel = CDLY_W'(ap_dly_r[1]);
      default: dly_sel = '0;
    endcase
    depth_sel = k_r[2] ? LENW'(ALLPASS_DEPTH) : LENW'(COMB_DEPTH);
    dly_p1    = LENW'(dly_sel) + LENW'(1);
    ring_len  = (dly_p1 > depth_sel) ? depth_sel : dly_p1;
    pos_ext   = LENW'(pos_r[k_r]);
    // A position left beyond a shortened ring restarts at the front.
    peff      = (pos_ext >= ring_len) ? '0 : pos_ext;
    peff_p1   = peff + LENW'(1);
    rd_idx    = (peff_p1 >= ring_len) ? '0 : peff_p1;
  end

  logic signed [SW+1:0]   sum_rnd;
  logic signed [SATW-1:0] hv, hd;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    x_nxt         = x_r;
    sum_nxt       = sum_r;
    v_nxt         = v_r;
    lpv_nxt       = lpv_r;
    peff_nxt      = peff_r;
    nidx_nxt      = nidx_r;
    pos_nxt       = pos_r;
    lp_nxt        = lp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    mac_ctl  = '0;
    mac_a    = x_r;
    mac_b    = m_eff;
    cm_we    = 1'b0;
    cm_waddr = {k_r[1:0], peff_r[CIW-1:0]};
    cm_wdata = '0;
    cm_raddr = {k_r[1:0], rd_idx[CIW-1:0]};
    am_we    = 1'b0;
    am_waddr = {k_r[0], peff_r[AIW-1:0]};
    am_wdata = '0;
    am_raddr = {k_r[0], rd_idx[AIW-1:0]};

    sum_rnd = sum_r + SUM_TWO;
    hv      = (SATW'(v_r) + ONE_S) >>> 1;
    hd      = (SATW'(am_rdata_r) + ONE_S) >>> 1;

    in_tready = (state_r == S_IDLE);

    case (state_r)
      S_CLEAR: begin
        cm_we    = ((clr_r >> CMW) == '0);
        cm_waddr = clr_r[CMW-1:0];
        am_we    = ((clr_r >> AMW) == '0);
        am_waddr = clr_r[AMW-1:0];
        clr_nxt  = clr_r + CLRW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata[SW-1:0];
          sum_nxt   = '0;
          k_nxt     = 3'd0;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        peff_nxt  = peff[PW-1:0];
        nidx_nxt  = rd_idx[PW-1:0];
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_a     = lp_r[k_r[1:0]];
        mac_b     = d_eff;
        state_nxt = S_CMAC;
      end
      S_CMAC: begin
        mac_ctl   = '{en: 1'b1, load: 1'b0};
        mac_a     = cm_rdata_r;
        mac_b     = one_m_d;
        sum_nxt   = sum_r + {{2{cm_rdata_r[SW-1]}}, cm_rdata_r};
        state_nxt = S_CLP;
      end
      S_CLP: begin
        lpv_nxt             = sat(SATW'(acc_sh));
        lp_nxt[k_r[1:0]]    = lpv_nxt;
        state_nxt           = S_CFB;
      end
      S_CFB: begin
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_a     = lpv_r;
        mac_b     = FEEDBACK;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cm_we        = 1'b1;
        cm_wdata     = sat(SATW'(x_r) + SATW'(acc_sh));
        pos_nxt[k_r] = nidx_r;
        k_nxt        = k_r + 3'd1;
        if (k_r == 3'd3) begin
          // Comb average with rounding, then on to the first allpass.
          v_nxt     = sum_rnd[SW+1:2];
          state_nxt = S_ARD;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_ARD: begin
        peff_nxt  = peff[PW-1:0];
        nidx_nxt  = rd_idx[PW-1:0];
        state_nxt = S_AWR;
      end
      S_AWR: begin
        am_we        = 1'b1;
        am_wdata     = sat(SATW'(v_r) + hd);
        v_nxt        = sat(SATW'(am_rdata_r) - hv);
        pos_nxt[k_r] = nidx_r;
        if (k_r == 3'd5) begin
          state_nxt = S_M1;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_ARD;
        end
      end
      S_M1: begin
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_a     = x_r;
        mac_b     = one_m_m;
        state_nxt = S_M2;
      end
      S_M2: begin
        mac_ctl   = '{en: 1'b1, load: 1'b0};
        mac_a     = v_r;
        mac_b     = m_eff;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = sat(SATW'(acc_sh));
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      k_r         <= 3'd0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        pos_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        lp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      lp_r        <= lp_nxt;
    end
    x_r    <= x_nxt;
    sum_r  <= sum_nxt;
    v_r    <= v_nxt;
    lpv_r  <= lpv_nxt;
    peff_r <= peff_nxt;
    nidx_r <= nidx_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cm_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) begin
      am_mem[am_waddr] <= am_wdata;
    end
    am_rdata_r <= am_mem[am_raddr];
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata         = '0;
    out_tdata[SW-1:0] = out_r;
  end

`ifndef SYNTHESIS
  a_no_io_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && !out_tvalid))
    else $error("stream handshake active during memory sweep");

  a_comb_stage_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRD || state_r == S_CMAC || state_r == S_CLP ||
     state_r == S_CFB || state_r == S_CWR) |-> !k_r[2])
    else $error("comb step running on an allpass index");

  a_ap_stage_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ARD || state_r == S_AWR) |-> (k_r == 3'd4 || k_r == 3'd5))
    else $error("allpass step running on a comb index");

  a_comb_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (LENW'(pos_r[0]) < LENW'(COMB_DEPTH)) && (LENW'(pos_r[1]) < LENW'(COMB_DEPTH)) &&
    (LENW'(pos_r[2]) < LENW'(COMB_DEPTH)) && (LENW'(pos_r[3]) < LENW'(COMB_DEPTH)))
    else $error("comb ring position outside storage");

  a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

// File: rtl/core/srv_mac.sv
// Shared multiply-accumulate unit: sample times unsigned coefficient.
module srv_mac
  import srv_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  mac_ctl_t                                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]                a,
  input  logic        [COEF_FRAC_BITS:0]                b,
  output logic signed [SAMPLE_WIDTH+COEF_FRAC_BITS+2:0] acc
);

  localparam int PW = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
  localparam int AW = SAMPLE_WIDTH + COEF_FRAC_BITS + 3;
  localparam logic signed [AW-1:0] HALF = AW'(64'd1 << (COEF_FRAC_BITS - 1));

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;

  // Load starts a new sum with the rounding half LSB already in it.
  always_comb begin
    prod = a * $signed({1'b0, b});
    if (ctl.load) begin
      acc_nxt = AW'(prod) + HALF;
    end else begin
      acc_nxt = acc_r + AW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
